// File: rtl/edt_pkg.sv
// ----------------------------------------------------------------------------
// edt_pkg
// Types and constants shared by the escaped delimiter tokenizer modules.
// ----------------------------------------------------------------------------
package edt_pkg;

	localparam int NUM_DELIM_REGS = 4;
	localparam int QUEUE_DEPTH    = 4;

	localparam logic [7:0] SPACE_BYTE     = 8'h20;
	localparam logic [7:0] BACKSLASH_BYTE = 8'h5C;
	localparam logic [7:0] NUL_BYTE       = 8'h00;

	localparam logic [2:0] REG_DELIM_0      = 3'd0;
	localparam logic [2:0] REG_DELIM_1      = 3'd1;
	localparam logic [2:0] REG_DELIM_2      = 3'd2;
	localparam logic [2:0] REG_DELIM_3      = 3'd3;
	localparam logic [2:0] REG_DELIM_COUNT  = 3'd4;
	localparam logic [2:0] REG_PREFIX_CHAR  = 3'd5;
	localparam logic [2:0] REG_STRIP_PREFIX = 3'd6;
	localparam logic [2:0] REG_SKIP_EMPTY   = 3'd7;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_string;
	} edt_in_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] out_byte;
		logic       run_last;
	} edt_out_t;

	typedef struct packed {
		logic       has_byte;
		logic       has_end;
		logic [7:0] data;
	} edt_desc_t;

endpackage

// File: rtl/edt_front.sv
// ----------------------------------------------------------------------------
// edt_front
// Holds the configuration and the token state, classifies each byte and
// pushes a descriptor of its results into the queue when it has any.
// ----------------------------------------------------------------------------
module edt_front #(
	parameter int MAX_DELIMS = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write,
	input  logic [2:0]       cfg_index,
	input  logic [7:0]       cfg_data,
	input  logic             in_valid,
	input  edt_pkg::edt_in_t in_data,
	input  logic             q_full,
	output logic             push,
	output edt_pkg::edt_desc_t desc
);
	import edt_pkg::*;

	localparam int NUM_DREG = (MAX_DELIMS < NUM_DELIM_REGS) ? MAX_DELIMS : NUM_DELIM_REGS;

	logic [7:0] delim_q [NUM_DREG];
	logic [2:0] delim_count_q;
	logic [7:0] prefix_q;
	logic       strip_q;
	logic       skip_q;

	logic esc_q, esc_d;
	logic bs_q, bs_d;
	logic tok_q, tok_d;

	logic [2:0] lim;
	logic       hit;
	logic       delim;
	logic       split;
	logic       emit;
	logic       ends;
	logic       end_out;
	logic       accept;
	logic [7:0] b;
	logic       eos;

	assign b      = in_data.in_byte;
	assign eos    = in_data.end_of_string;
	assign accept = in_valid && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_DREG; k++) begin
				delim_q[k] <= (k == 0) ? SPACE_BYTE : NUL_BYTE;
			end
			delim_count_q <= 3'd1;
			prefix_q      <= NUL_BYTE;
			strip_q       <= 1'b1;
			skip_q        <= 1'b0;
		end else if (cfg_write) begin
			for (int k = 0; k < NUM_DREG; k++) begin
				if (cfg_index == 3'(k)) begin
					delim_q[k] <= cfg_data;
				end
			end
			case (cfg_index)
				REG_DELIM_COUNT:  delim_count_q <= cfg_data[2:0];
				REG_PREFIX_CHAR:  prefix_q      <= cfg_data;
				REG_STRIP_PREFIX: strip_q       <= cfg_data[0];
				REG_SKIP_EMPTY:   skip_q        <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign lim = (delim_count_q > 3'(NUM_DREG)) ? 3'(NUM_DREG) : delim_count_q;

	always_comb begin
		hit = 1'b0;
		for (int k = 0; k < NUM_DREG; k++) begin
			if ((3'(k) < lim) && (delim_q[k] == b)) begin
				hit = 1'b1;
			end
		end
	end

	assign delim = hit && !((b == SPACE_BYTE) && bs_q);

	always_comb begin
		split = 1'b0;
		emit  = 1'b0;
		esc_d = esc_q;
		if (prefix_q != NUL_BYTE) begin
			if (delim) begin
				if (!esc_q) begin
					split = 1'b1;
				end else begin
					esc_d = 1'b0;
					emit  = 1'b1;
				end
			end else if (b == prefix_q) begin
				if (esc_q) begin
					esc_d = 1'b0;
					emit  = 1'b1;
				end else begin
					esc_d = 1'b1;
					emit  = !strip_q;
				end
			end else begin
				esc_d = 1'b0;
				emit  = 1'b1;
			end
		end else if (delim) begin
			split = 1'b1;
		end else begin
			emit = 1'b1;
		end
		if (eos) begin
			esc_d = 1'b0;
			bs_d  = 1'b0;
		end else begin
			bs_d = (b == BACKSLASH_BYTE);
		end
	end

	assign ends    = split || eos;
	assign end_out = ends && (tok_q || emit || !skip_q || eos);
	assign tok_d   = ends ? 1'b0 : (tok_q || emit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q <= 1'b0;
			bs_q  <= 1'b0;
			tok_q <= 1'b0;
		end else if (accept) begin
			esc_q <= esc_d;
			bs_q  <= bs_d;
			tok_q <= tok_d;
		end
	end

	assign push          = accept && (emit || end_out);
	assign desc.has_byte = emit;
	assign desc.has_end  = end_out;
	assign desc.data     = b;

endmodule

// File: rtl/edt_queue.sv
// ----------------------------------------------------------------------------
// edt_queue
// Short register queue of result descriptors between front and back.
// ----------------------------------------------------------------------------
module edt_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  edt_pkg::edt_desc_t push_desc,
	input  logic               pop,
	output edt_pkg::edt_desc_t head,
	output logic               full,
	output logic               empty
);
	import edt_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	edt_desc_t         mem [QUEUE_DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [PW:0]       count_q;

	assign full  = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/edt_back.sv
// ----------------------------------------------------------------------------
// edt_back
// Expands queued descriptors into result requests through an output register.
// ----------------------------------------------------------------------------
module edt_back (
	input  logic               clk,
	input  logic               arst_n,
	input  edt_pkg::edt_desc_t head,
	input  logic               empty,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output edt_pkg::edt_out_t  out_data
);
	import edt_pkg::*;

	logic      out_valid_q, out_valid_d;
	edt_out_t  out_q, out_d;
	logic      phase_q, phase_d;
	logic      load;

	assign load = !out_valid_q || !out_stall;

	always_comb begin
		out_valid_d = out_valid_q;
		out_d       = out_q;
		phase_d     = phase_q;
		pop         = 1'b0;
		if (load) begin
			out_valid_d = !empty;
			if (!empty) begin
				if (!phase_q && head.has_byte) begin
					out_d.kind     = KIND_BYTE;
					out_d.out_byte = head.data;
					out_d.run_last = !head.has_end;
					if (head.has_end) begin
						phase_d = 1'b1;
					end else begin
						pop = 1'b1;
					end
				end else begin
					out_d.kind     = KIND_END;
					out_d.out_byte = NUL_BYTE;
					out_d.run_last = 1'b1;
					phase_d        = 1'b0;
					pop            = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else begin
			out_valid_q <= out_valid_d;
			phase_q     <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		out_q <= out_d;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: rtl/escaped_delimiter_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// escaped_delimiter_tokenizer_unit
// Splits a byte stream into tokens at configured delimiters with escaping.
//
// Input channel in_valid/in_stall/in_data carries one byte and its
// end-of-string flag per request. Output channel out_valid/out_stall/
// out_data carries token bytes and token-end marks; run_last flags the
// last result of an input byte. A byte may cause zero, one or two results.
// Results of a byte pass through the descriptor queue and the output register.
// Throughput: one byte per cycle while the queue is not full; a byte with two
// results holds the output register for each; the four-entry queue absorbs
// that. in_stall rises only when the queue is full, so a stalled receiver
// backs up through the queue after four pending descriptors.
// Configuration: cfg_write with cfg_index/cfg_data, only while idle.
// Reset: delimiter 0 is space and the only one active, escaping off, strip
// mode on, empty tokens kept; the token state and queue are cleared.
// ----------------------------------------------------------------------------
module escaped_delimiter_tokenizer_unit #(
	parameter int MAX_DELIMS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [2:0]        cfg_index,
	input  logic [7:0]        cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  edt_pkg::edt_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output edt_pkg::edt_out_t out_data
);
	import edt_pkg::*;

	logic      push;
	logic      pop;
	logic      q_full;
	logic      q_empty;
	edt_desc_t push_desc;
	edt_desc_t head;

	assign in_stall = q_full;

	edt_front #(.MAX_DELIMS(MAX_DELIMS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.q_full    (q_full),
		.push      (push),
		.desc      (push_desc)
	);

	edt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	edt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (q_empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind == KIND_END |-> out_data.run_last && out_data.out_byte == NUL_BYTE)
		else $error("token end not last or carries data");

	a_byte_then_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_data.run_last |=> out_valid && out_data.kind == KIND_END)
		else $error("non-last token byte not followed by token end");

	a_stall_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(push))
		else $error("queue filled without a push");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("pop from empty queue");

endmodule
